FILE: sv/first_fit_heap_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Shared shorthand for clocked assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define FFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge out of reset.
`define FFA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;

  // Status codes carried in the output tuser.
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NO_SPACE  = 2'd1;
  localparam logic [1:0] STS_IGNORED   = 2'd2;
  localparam logic [1:0] STS_NOT_BLOCK = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_AWALK,
    ST_AFOUND,
    ST_AWRITE,
    ST_LWALK,
    ST_FREE_RD,
    ST_FREE_MARK,
    ST_MRD0,
    ST_MHEAD,
    ST_MWALK,
    ST_RESP
  } ffa_state_t;

  // Requests to the spare entry pool.
  typedef struct packed {
    logic pop;
    logic push;
  } ffa_spare_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ffa_entry_mem.sv
// ----------------------------------------------------------------------------
// ffa_entry_mem
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_entry_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 56
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/ffa_spare_pool.sv
// ----------------------------------------------------------------------------
// ffa_spare_pool
// Hands out unused table entries: a fill count of never used entries plus a
// stack of entries returned by merging.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_spare_pool #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ffa_pkg::ffa_spare_ctl_t       ctl,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0] push_idx,
  output logic                               avail,
  output logic      [$clog2(MAX_BLOCKS)-1:0] top_idx
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);

  logic [IW-1:0] stack [MAX_BLOCKS];
  logic [NW-1:0] fresh_r, fresh_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] top_q;
  logic [NW-1:0] rd_ptr;

  // Counters: entry 0 is in use from reset, so fresh entries start at 1.
  always_comb begin
    fresh_nxt = fresh_r;
    cnt_nxt   = cnt_r;
    if (ctl.push) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (ctl.pop) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - NW'(1);
      end else begin
        fresh_nxt = fresh_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= NW'(1);
      cnt_r   <= '0;
    end else begin
      fresh_r <= fresh_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Stack of returned entries, top read every cycle.
  assign rd_ptr = (cnt_r != '0) ? cnt_r - NW'(1) : '0;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stack[cnt_r[IW-1:0]] <= push_idx;
    end
  end

  always_ff @(posedge clk) begin
    top_q <= stack[rd_ptr[IW-1:0]];
  end

  assign avail   = (cnt_r != '0) || (fresh_r != NW'(MAX_BLOCKS));
  assign top_idx = (cnt_r != '0) ? top_q : fresh_r[IW-1:0];

endmodule

`default_nettype wire

FILE: sv/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a fixed pool with a bounded table of blocks.
// ----------------------------------------------------------------------------
// One command is handled at a time. The block list lives in a table memory
// with a registered read, and the sequencer follows it one entry per cycle.
// An allocate walks the list to the first fit, splits off the remainder when
// there is room, and writes the block. A free walks to its block, reads and
// marks it free, then makes a merge pass over the whole list; a moving
// reallocate adds an allocate walk. After reset the block writes the
// initial free block before it takes a command. A result waits in an output
// register, and the next command is taken as soon as the previous result
// has been loaded there.
`default_nettype none

`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator #(
  parameter int POOL_BYTES   = 8388608,
  parameter int HEADER_BYTES = 12,
  parameter int MAX_BLOCKS   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: pool_base.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  // Command beats. tdata: request_size[23:0], address[55:24].
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,
  // tuser: cmd[1:0].
  input  wire logic [1:0]  in_tuser,
  // Result beats. tdata: result_address[31:0], copy_length[55:32].
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [55:0] out_tdata,
  // tuser: status[1:0].
  output logic      [1:0]  out_tuser
);

  localparam int OW = $clog2(POOL_BYTES);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 2 * OW + 1 + NW;
  localparam int CW = 34;
  localparam logic [NW-1:0] END_IDX = NW'(MAX_BLOCKS);
  localparam logic [CW-1:0] HDR_W   = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] POOL_W  = CW'(POOL_BYTES);

  ffa_pkg::ffa_state_t state_r, state_nxt;

  logic [1:0]    cmd_r, cmd_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [23:0]   raw_r, raw_nxt;
  logic [24:0]   need_r, need_nxt;
  logic [OW-1:0] rel_r, rel_nxt;
  logic [IW-1:0] walk_r, walk_nxt;
  logic [IW-1:0] old_idx_r, old_idx_nxt;
  logic [OW-1:0] old_size_r, old_size_nxt;
  logic [IW-1:0] cur_idx_r, cur_idx_nxt;
  logic [OW-1:0] cur_off_r, cur_off_nxt;
  logic [OW-1:0] cur_size_r, cur_size_nxt;
  logic          cur_free_r, cur_free_nxt;
  logic [NW-1:0] cur_next_r, cur_next_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic [23:0]   copy_r, copy_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_addr_r, out_addr_nxt;
  logic [23:0]   out_copy_r, out_copy_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   pool_base_r;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic [OW-1:0] rd_off, rd_size;
  logic          rd_free;
  logic [NW-1:0] rd_next;

  ffa_pkg::ffa_spare_ctl_t spare_ctl;
  logic                    spare_avail;
  logic [IW-1:0]           spare_top;

  logic          in_beat;
  logic [23:0]   in_size;
  logic [31:0]   in_addr;
  logic [32:0]   pool_limit;
  logic          out_of_range;
  logic [31:0]   in_rel;
  logic [24:0]   in_need;
  logic          split_ok;

  // Table memory and spare entry pool.
  ffa_entry_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffa_spare_pool #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_spare (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (spare_ctl),
    .push_idx (walk_r),
    .avail    (spare_avail),
    .top_idx  (spare_top)
  );

  // Entry fields as read: {next, free, size, offset}.
  assign rd_off  = mem_rdata[OW-1:0];
  assign rd_size = mem_rdata[2*OW-1:OW];
  assign rd_free = mem_rdata[2*OW];
  assign rd_next = mem_rdata[EW-1:2*OW+1];

  // Configuration register, written only while idle.
  assign cfg_ready = (state_r == ffa_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= 32'hC000_1000;
    end else if (cfg_valid && cfg_ready) begin
      pool_base_r <= cfg_data;
    end
  end

  // Command decode helpers.
  assign in_tready    = (state_r == ffa_pkg::ST_IDLE);
  assign in_beat      = in_tvalid && in_tready;
  assign in_size      = in_tdata[23:0];
  assign in_addr      = in_tdata[55:24];
  assign pool_limit   = {1'b0, pool_base_r} + 33'(POOL_BYTES);
  assign out_of_range = (in_addr < pool_base_r) || ({1'b0, in_addr} >= pool_limit);
  assign in_rel       = in_addr - pool_base_r;
  assign in_need      = ({1'b0, in_size} + 25'd3) & ~25'd3;

  // Split test on the block found by the allocate walk.
  assign split_ok = (CW'(cur_size_r) >= CW'(need_r) + HDR_W + CW'(4)) &&
                    (CW'(cur_off_r) + HDR_W + HDR_W + CW'(need_r) < POOL_W) &&
                    spare_avail;

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    raw_nxt        = raw_r;
    need_nxt       = need_r;
    rel_nxt        = rel_r;
    walk_nxt       = walk_r;
    old_idx_nxt    = old_idx_r;
    old_size_nxt   = old_size_r;
    cur_idx_nxt    = cur_idx_r;
    cur_off_nxt    = cur_off_r;
    cur_size_nxt   = cur_size_r;
    cur_free_nxt   = cur_free_r;
    cur_next_nxt   = cur_next_r;
    res_addr_nxt   = res_addr_r;
    copy_nxt       = copy_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_copy_nxt   = out_copy_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    spare_ctl      = '0;

    case (state_r)
      ffa_pkg::ST_INIT: begin
        // One free block covering the pool behind the first header.
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {END_IDX, 1'b1, OW'(POOL_BYTES - HEADER_BYTES), {OW{1'b0}}};
        state_nxt = ffa_pkg::ST_IDLE;
      end

      ffa_pkg::ST_IDLE: begin
        if (in_beat) begin
          cmd_nxt      = in_tuser;
          addr_nxt     = in_addr;
          raw_nxt      = in_size;
          need_nxt     = in_need;
          rel_nxt      = OW'(in_rel - 32'(HEADER_BYTES));
          res_addr_nxt = '0;
          copy_nxt     = '0;
          status_nxt   = ffa_pkg::STS_OK;
          if (in_tuser == ffa_pkg::CMD_ALLOC ||
              (in_tuser == ffa_pkg::CMD_REALLOC && in_addr == '0)) begin
            mem_re    = 1'b1;
            walk_nxt  = '0;
            state_nxt = ffa_pkg::ST_AWALK;
          end else if (in_tuser == ffa_pkg::CMD_FREE || in_tuser == ffa_pkg::CMD_REALLOC) begin
            if (in_addr == '0 || out_of_range) begin
              status_nxt = ffa_pkg::STS_IGNORED;
              state_nxt  = ffa_pkg::ST_RESP;
            end else if (in_rel < 32'(HEADER_BYTES)) begin
              status_nxt = ffa_pkg::STS_NOT_BLOCK;
              state_nxt  = ffa_pkg::ST_RESP;
            end else begin
              mem_re    = 1'b1;
              walk_nxt  = '0;
              state_nxt = ffa_pkg::ST_LWALK;
            end
          end else begin
            status_nxt = ffa_pkg::STS_IGNORED;
            state_nxt  = ffa_pkg::ST_RESP;
          end
        end
      end

      ffa_pkg::ST_AWALK: begin
        // First free block large enough for the rounded request.
        if (rd_free && CW'(rd_size) >= CW'(need_r)) begin
          cur_idx_nxt  = walk_r;
          cur_off_nxt  = rd_off;
          cur_size_nxt = rd_size;
          cur_free_nxt = rd_free;
          cur_next_nxt = rd_next;
          state_nxt    = ffa_pkg::ST_AFOUND;
        end else if (rd_next == END_IDX) begin
          status_nxt = ffa_pkg::STS_NO_SPACE;
          state_nxt  = ffa_pkg::ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_next[IW-1:0];
          walk_nxt  = rd_next[IW-1:0];
        end
      end

      ffa_pkg::ST_AFOUND: begin
        // Split the remainder off as a new free block.
        if (split_ok) begin
          mem_we        = 1'b1;
          mem_waddr     = spare_top;
          mem_wdata     = {cur_next_r, 1'b1,
                           OW'(CW'(cur_size_r) - CW'(need_r) - HDR_W),
                           OW'(CW'(cur_off_r) + HDR_W + CW'(need_r))};
          spare_ctl.pop = 1'b1;
          cur_next_nxt  = NW'(spare_top);
          cur_size_nxt  = OW'(need_r);
        end
        state_nxt = ffa_pkg::ST_AWRITE;
      end

      ffa_pkg::ST_AWRITE: begin
        mem_we       = 1'b1;
        mem_waddr    = cur_idx_r;
        mem_wdata    = {cur_next_r, 1'b0, cur_size_r, cur_off_r};
        res_addr_nxt = pool_base_r + 32'(cur_off_r) + 32'(HEADER_BYTES);
        if (cmd_r == ffa_pkg::CMD_REALLOC && addr_r != '0) begin
          copy_nxt  = 24'(old_size_r);
          state_nxt = ffa_pkg::ST_FREE_RD;
        end else begin
          state_nxt = ffa_pkg::ST_RESP;
        end
      end

      ffa_pkg::ST_LWALK: begin
        // Find the block whose header sits right before the address.
        if (rd_off == rel_r) begin
          old_idx_nxt  = walk_r;
          old_size_nxt = rd_size;
          if (cmd_r == ffa_pkg::CMD_FREE) begin
            state_nxt = ffa_pkg::ST_FREE_RD;
          end else if (CW'(rd_size) >= CW'(raw_r)) begin
            res_addr_nxt = addr_r;
            state_nxt    = ffa_pkg::ST_RESP;
          end else begin
            mem_re    = 1'b1;
            walk_nxt  = '0;
            state_nxt = ffa_pkg::ST_AWALK;
          end
        end else if (rd_next == END_IDX) begin
          status_nxt = ffa_pkg::STS_NOT_BLOCK;
          state_nxt  = ffa_pkg::ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_next[IW-1:0];
          walk_nxt  = rd_next[IW-1:0];
        end
      end

      ffa_pkg::ST_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = old_idx_r;
        state_nxt = ffa_pkg::ST_FREE_MARK;
      end

      ffa_pkg::ST_FREE_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = old_idx_r;
        mem_wdata = {rd_next, 1'b1, rd_size, rd_off};
        state_nxt = ffa_pkg::ST_MRD0;
      end

      ffa_pkg::ST_MRD0: begin
        mem_re    = 1'b1;
        walk_nxt  = '0;
        state_nxt = ffa_pkg::ST_MHEAD;
      end

      ffa_pkg::ST_MHEAD: begin
        cur_idx_nxt  = walk_r;
        cur_off_nxt  = rd_off;
        cur_size_nxt = rd_size;
        cur_free_nxt = rd_free;
        cur_next_nxt = rd_next;
        if (rd_next == END_IDX) begin
          state_nxt = ffa_pkg::ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_next[IW-1:0];
          walk_nxt  = rd_next[IW-1:0];
          state_nxt = ffa_pkg::ST_MWALK;
        end
      end

      ffa_pkg::ST_MWALK: begin
        // Merge the pair when both are free, else step on.
        if (cur_free_r && rd_free) begin
          cur_size_nxt   = OW'(CW'(cur_size_r) + HDR_W + CW'(rd_size));
          cur_next_nxt   = rd_next;
          mem_we         = 1'b1;
          mem_waddr      = cur_idx_r;
          mem_wdata      = {rd_next, cur_free_r,
                            OW'(CW'(cur_size_r) + HDR_W + CW'(rd_size)), cur_off_r};
          spare_ctl.push = 1'b1;
        end else begin
          cur_idx_nxt  = walk_r;
          cur_off_nxt  = rd_off;
          cur_size_nxt = rd_size;
          cur_free_nxt = rd_free;
          cur_next_nxt = rd_next;
        end
        if (rd_next == END_IDX) begin
          state_nxt = ffa_pkg::ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_next[IW-1:0];
          walk_nxt  = rd_next[IW-1:0];
        end
      end

      ffa_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_copy_nxt   = copy_r;
          out_status_nxt = status_r;
          state_nxt      = ffa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ffa_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffa_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    raw_r        <= raw_nxt;
    need_r       <= need_nxt;
    rel_r        <= rel_nxt;
    walk_r       <= walk_nxt;
    old_idx_r    <= old_idx_nxt;
    old_size_r   <= old_size_nxt;
    cur_idx_r    <= cur_idx_nxt;
    cur_off_r    <= cur_off_nxt;
    cur_size_r   <= cur_size_nxt;
    cur_free_r   <= cur_free_nxt;
    cur_next_r   <= cur_next_nxt;
    res_addr_r   <= res_addr_nxt;
    copy_r       <= copy_nxt;
    status_r     <= status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_copy_r   <= out_copy_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_copy_r, out_addr_r};
  assign out_tuser  = out_status_r;

  // Checks on the sequencer.
  `FFA_ASSERT_IMPLY(a_out_from_resp, $rose(out_valid_r),
                    $past(state_r) == ffa_pkg::ST_RESP,
                    "result beat not from response state")
  `FFA_ASSERT_IMPLY(a_pop_avail, spare_ctl.pop, spare_avail,
                    "spare entry taken from an empty pool")
  `FFA_ASSERT(a_pop_push, !(spare_ctl.pop && spare_ctl.push),
              "spare pop and push in one cycle")
  `FFA_ASSERT_IMPLY(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr,
                    "table read and write hit one entry")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate, free and reallocate commands through the stream ports and
// compares every result beat with a cycle-free model of the block list.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 8388608;
  localparam int HDR = 12;
  localparam int NBLK = 256;
  localparam int ENDL = NBLK;
  localparam int LIMIT = 3000000;
  // Command code that the block does not know.
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0] out_tuser;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One expected result beat.
  typedef struct {
    logic [31:0] addr;
    logic [23:0] copy;
    logic [1:0] sts;
  } grant_t;

  grant_t grants_due[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  // Model of the block table.
  logic [31:0] base_addr;
  int unsigned b_off[NBLK];
  int unsigned b_size[NBLK];
  bit b_free[NBLK];
  int unsigned b_next[NBLK];
  bit b_spare[NBLK];
  logic [31:0] live_addr[$];

  function automatic void model_reset();
    base_addr = 32'hC000_1000;
    for (int i = 0; i < NBLK; i++) begin
      b_off[i] = 0; b_size[i] = 0; b_free[i] = 0; b_next[i] = ENDL; b_spare[i] = 1;
    end
    b_size[0] = POOL - HDR;
    b_free[0] = 1;
    b_spare[0] = 0;
  endfunction

  function automatic logic [31:0] user_of(int unsigned idx);
    return base_addr + b_off[idx] + HDR;
  endfunction

  // First fit with optional split; returns ENDL when nothing fits.
  function automatic int unsigned first_fit(int unsigned raw);
    int unsigned need, cur, nb;
    longint unsigned split_end;
    need = (raw + 3) & ~32'd3;
    cur = 0;
    for (int g = 0; g < NBLK && cur < NBLK; g++) begin
      if (b_free[cur] && b_size[cur] >= need) begin
        split_end = longint'(b_off[cur]) + HDR + need + HDR;
        if (longint'(b_size[cur]) >= longint'(need) + HDR + 4 && split_end < POOL) begin
          nb = ENDL;
          for (int i = 0; i < NBLK; i++)
            if (b_spare[i] && nb == ENDL) nb = i;
          if (nb != ENDL) begin
            b_spare[nb] = 0;
            b_off[nb] = b_off[cur] + HDR + need;
            b_size[nb] = b_size[cur] - need - HDR;
            b_free[nb] = 1;
            b_next[nb] = b_next[cur];
            b_next[cur] = nb;
            b_size[cur] = need;
          end
        end
        b_free[cur] = 0;
        return cur;
      end
      cur = b_next[cur];
    end
    return ENDL;
  endfunction

  // Returns a status code; idx gets the block entry on success.
  function automatic logic [1:0] find_block(logic [31:0] a, output int unsigned idx);
    longint unsigned rel;
    int unsigned cur;
    idx = 0;
    if (longint'(a) < longint'(base_addr) ||
        longint'(a) >= longint'(base_addr) + POOL) return ffa_pkg::STS_IGNORED;
    rel = longint'(a) - longint'(base_addr);
    if (rel < HDR) return ffa_pkg::STS_NOT_BLOCK;
    rel -= HDR;
    cur = 0;
    for (int g = 0; g < NBLK && cur < NBLK; g++) begin
      if (longint'(b_off[cur]) == rel) begin
        idx = cur;
        return ffa_pkg::STS_OK;
      end
      cur = b_next[cur];
    end
    return ffa_pkg::STS_NOT_BLOCK;
  endfunction

  function automatic void release_block(int unsigned idx);
    int unsigned cur, nx;
    cur = 0;
    b_free[idx] = 1;
    for (int g = 0; g < 2 * NBLK && cur < NBLK; g++) begin
      nx = b_next[cur];
      if (nx >= NBLK) break;
      if (b_free[cur] && b_free[nx]) begin
        b_size[cur] = b_size[cur] + HDR + b_size[nx];
        b_next[cur] = b_next[nx];
        b_spare[nx] = 1;
      end else begin
        cur = nx;
      end
    end
  endfunction

  function automatic grant_t predict_grant(logic [1:0] cmd, logic [23:0] req,
                                           logic [31:0] a);
    grant_t g;
    int unsigned idx, nb;
    logic [1:0] r;
    g = '{32'd0, 24'd0, ffa_pkg::STS_OK};
    if (cmd == ffa_pkg::CMD_ALLOC || (cmd == ffa_pkg::CMD_REALLOC && a == 0)) begin
      nb = first_fit(req);
      if (nb != ENDL) g.addr = user_of(nb);
      else g.sts = ffa_pkg::STS_NO_SPACE;
    end else if (cmd == ffa_pkg::CMD_FREE) begin
      if (a == 0) g.sts = ffa_pkg::STS_IGNORED;
      else begin
        r = find_block(a, idx);
        if (r == ffa_pkg::STS_OK) release_block(idx);
        else g.sts = r;
      end
    end else if (cmd == ffa_pkg::CMD_REALLOC) begin
      r = find_block(a, idx);
      if (r != ffa_pkg::STS_OK) g.sts = r;
      else if (b_size[idx] >= req) g.addr = a;
      else begin
        nb = first_fit(req);
        if (nb != ENDL) begin
          g.addr = user_of(nb);
          g.copy = 24'(b_size[idx]);
          release_block(idx);
        end else begin
          g.sts = ffa_pkg::STS_NO_SPACE;
        end
      end
    end else begin
      g.sts = ffa_pkg::STS_IGNORED;
    end
    if (g.sts == ffa_pkg::STS_OK && g.addr != 0) live_addr.push_back(g.addr);
    return g;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall and check against the oldest expectation.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (grants_due.size() == 0) begin
        $error("result beat with no expectation");
        errors++;
      end else begin
        grant_t e;
        e = grants_due.pop_front();
        if (out_tdata[31:0] !== e.addr) begin
          $error("result_address expected %h actual %h", e.addr, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[55:32] !== e.copy) begin
          $error("copy_length expected %0d actual %0d", e.copy, out_tdata[55:32]);
          errors++;
        end
        if (out_tuser !== e.sts) begin
          $error("status expected %0d actual %0d", e.sts, out_tuser);
          errors++;
        end
      end
    end
    out_tready <= calm || ($urandom_range(99) >= 30);
  end

  // Valid stays high across back-to-back beats and drops only while idling.
  task automatic send_cmd(logic [1:0] cmd, logic [23:0] req, logic [31:0] a,
                          bit typed, grant_t want);
    grant_t g;
    if (!calm && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 30);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {a, req};
    g = predict_grant(cmd, req, a);
    if (typed && (g.addr !== want.addr || g.sts !== want.sts)) begin
      $error("directed row disagrees with model: addr %h sts %0d", g.addr, g.sts);
      errors++;
    end
    grants_due.push_back(typed ? want : g);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain(int tail);
    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_addr = v;
    live_addr.delete();
  endtask

  // Pick a random address biased toward live blocks.
  function automatic logic [31:0] pick_addr();
    int k;
    k = $urandom_range(99);
    if (live_addr.size() != 0 && k < 70) return live_addr[$urandom_range(live_addr.size() - 1)];
    if (k < 78) return 32'd0;
    if (k < 88) return base_addr + $urandom_range(POOL - 1);
    if (k < 92) return base_addr + HDR;
    return $urandom;
  endfunction

  function automatic logic [23:0] pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 70) return 24'($urandom_range(200));
    if (k < 90) return 24'($urandom_range(70000));
    if (k < 95) return 24'hFFFFFF;
    return 24'($urandom_range(POOL));
  endfunction

  // Directed rows: typed expectations only where obvious.
  typedef struct {
    logic [1:0] cmd;
    logic [23:0] req;
    logic [31:0] a;
    bit typed;
    logic [31:0] want_addr;
    logic [1:0] want_sts;
  } row_t;

  row_t rows[$];

  initial begin
    logic [31:0] b;
    logic [1:0] c;
    model_reset();
    b = 32'hC000_1000;
    rows = '{
      '{ffa_pkg::CMD_ALLOC, 24'd0, 32'd0, 1, b + HDR, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_ALLOC, 24'd1, 32'd0, 0, 0, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_ALLOC, 24'd5, 32'd0, 0, 0, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_ALLOC, 24'hFFFFFF, 32'd0, 1, 32'd0, ffa_pkg::STS_NO_SPACE},
      '{ffa_pkg::CMD_FREE, 24'd0, 32'd0, 1, 32'd0, ffa_pkg::STS_IGNORED},
      '{ffa_pkg::CMD_FREE, 24'hFFFFFF, 32'hFFFFFFFF, 1, 32'd0, ffa_pkg::STS_IGNORED},
      '{ffa_pkg::CMD_FREE, 24'd0, b - 1, 1, 32'd0, ffa_pkg::STS_IGNORED},
      '{ffa_pkg::CMD_FREE, 24'd0, b + POOL, 1, 32'd0, ffa_pkg::STS_IGNORED},
      '{ffa_pkg::CMD_FREE, 24'd0, b, 1, 32'd0, ffa_pkg::STS_NOT_BLOCK},
      '{ffa_pkg::CMD_FREE, 24'd0, b + HDR + 2, 1, 32'd0, ffa_pkg::STS_NOT_BLOCK},
      '{CMD_NONE, 24'hFFFFFF, 32'hFFFFFFFF, 1, 32'd0, ffa_pkg::STS_IGNORED},
      '{ffa_pkg::CMD_REALLOC, 24'd0, b + 7, 1, 32'd0, ffa_pkg::STS_NOT_BLOCK},
      '{ffa_pkg::CMD_REALLOC, 24'd4, 32'd5, 1, 32'd0, ffa_pkg::STS_IGNORED},
      '{ffa_pkg::CMD_REALLOC, 24'd0, b + HDR, 1, b + HDR, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_REALLOC, 24'd3, b + HDR, 0, 0, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_REALLOC, 24'd64, b + HDR, 0, 0, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_REALLOC, 24'hFFFFFF, b + HDR + 12, 0, 0, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_REALLOC, 24'd16, 32'd0, 0, 0, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_FREE, 24'd0, b + HDR + 12, 0, 0, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_FREE, 24'd0, b + HDR + 12, 0, 0, ffa_pkg::STS_OK},
      '{ffa_pkg::CMD_ALLOC, 24'd8388608, 32'd0, 1, 32'd0, ffa_pkg::STS_NO_SPACE},
      '{ffa_pkg::CMD_ALLOC, 24'd8388596, 32'd0, 0, 0, ffa_pkg::STS_OK}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_cmd(rows[i].cmd, rows[i].req, rows[i].a, rows[i].typed,
               '{rows[i].want_addr, 24'd0, rows[i].want_sts});
    // Clean the table before moving the pool: free every live block.
    while (live_addr.size() != 0)
      send_cmd(ffa_pkg::CMD_FREE, 24'd0, live_addr.pop_front(), 0, '{0, 0, 0});

    // Random phases under several pool bases, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      drain(2 * NBLK + 40);
      case (ph)
        0: write_base(32'd0);
        1: write_base(32'hFFFF_FFFF - POOL + 1);
        2: write_base(32'hFFFF_FFFF);
        3: write_base($urandom);
        default: write_base(32'hC000_1000);
      endcase
      for (int n = 0; n < 130; n++) begin
        calm = (ph == 1 && n >= 40 && n < 90);
        c = $urandom_range(99) < 45 ? ffa_pkg::CMD_ALLOC :
            ($urandom_range(99) < 60 ? ffa_pkg::CMD_FREE :
            ($urandom_range(99) < 95 ? ffa_pkg::CMD_REALLOC : CMD_NONE));
        if (c == ffa_pkg::CMD_FREE && live_addr.size() != 0 && $urandom_range(99) < 80) begin
          int k;
          k = $urandom_range(live_addr.size() - 1);
          send_cmd(c, 24'($urandom), live_addr[k], 0, '{0, 0, 0});
          live_addr.delete(k);
        end else begin
          send_cmd(c, pick_size(), pick_addr(), 0, '{0, 0, 0});
        end
      end
      calm = 1'b0;
    end

    drain(2 * NBLK + 40);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
